### sv/gspd_pkg.sv
// Shared types and constants for the gain-scheduled PD force controller.
// Holds the register map, the microcode word layout and the gain bundle.
// No dependencies; every other file imports this package.
`default_nettype none

package gspd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 16;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ENABLE      = 3'd0;
    localparam cfg_idx_t REG_P_GAIN_LOW  = 3'd1;
    localparam cfg_idx_t REG_P_GAIN_MID  = 3'd2;
    localparam cfg_idx_t REG_P_GAIN_HIGH = 3'd3;
    localparam cfg_idx_t REG_D_GAIN_LOW  = 3'd4;
    localparam cfg_idx_t REG_D_GAIN_MID  = 3'd5;
    localparam cfg_idx_t REG_D_GAIN_HIGH = 3'd6;
    localparam cfg_idx_t REG_INERTIA     = 3'd7;

    localparam logic [GAIN_W-1:0] P_GAIN_LOW_RST  = 24'd641420;
    localparam logic [GAIN_W-1:0] P_GAIN_MID_RST  = 24'd657896;
    localparam logic [GAIN_W-1:0] P_GAIN_HIGH_RST = 24'd659508;
    localparam logic [GAIN_W-1:0] D_GAIN_LOW_RST  = 24'd78407;
    localparam logic [GAIN_W-1:0] D_GAIN_MID_RST  = 24'd210954;
    localparam logic [GAIN_W-1:0] D_GAIN_HIGH_RST = 24'd277453;
    localparam logic [GAIN_W-1:0] INERTIA_RST     = 24'd117067;

    typedef logic [1:0] sector_t;

    localparam sector_t SECTOR_LOW  = 2'd0;
    localparam sector_t SECTOR_MID  = 2'd1;
    localparam sector_t SECTOR_HIGH = 2'd2;

    typedef struct packed {
        logic                   enable;
        logic [2:0][GAIN_W-1:0] p_gain;
        logic [2:0][GAIN_W-1:0] d_gain;
        logic [GAIN_W-1:0]      inertia;
    } gains_t;

    typedef enum logic [2:0] {
        ACC_NOP,
        ACC_LOAD,
        ACC_ADD,
        ACC_VTERM,
        ACC_S1,
        ACC_ROUND,
        ACC_FINAL
    } acc_op_t;

    typedef enum logic [1:0] {
        A_VEL,
        A_PERR,
        A_VERR,
        A_S1
    } a_sel_t;

    typedef enum logic [1:0] {
        B_VEL_COEF,
        B_KP,
        B_KD,
        B_INERTIA
    } b_sel_t;

    typedef enum logic {
        COND_NONE,
        COND_OUT_STALL
    } cond_t;

    typedef struct packed {
        acc_op_t           acc_op;
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        logic              hi;
        logic              peak_upd;
        logic              sect_upd;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   exec;
        ucode_t uc;
    } ctrl_t;

endpackage

`default_nettype wire

### sv/gspd_cfg.sv
// Configuration register bank: enable, sector gains and inertia factor.
// Depends on gspd_pkg for the register map and reset values.
`default_nettype none

module gspd_cfg
    import gspd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [GAIN_W-1:0] cfg_data,
    output gains_t            gains
);

    gains_t gains_reg;
    gains_t gains_next;

    assign cfg_ready = 1'b1;
    assign gains     = gains_reg;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ENABLE:      gains_next.enable    = cfg_data[0];
                REG_P_GAIN_LOW:  gains_next.p_gain[0] = cfg_data;
                REG_P_GAIN_MID:  gains_next.p_gain[1] = cfg_data;
                REG_P_GAIN_HIGH: gains_next.p_gain[2] = cfg_data;
                REG_D_GAIN_LOW:  gains_next.d_gain[0] = cfg_data;
                REG_D_GAIN_MID:  gains_next.d_gain[1] = cfg_data;
                REG_D_GAIN_HIGH: gains_next.d_gain[2] = cfg_data;
                REG_INERTIA:     gains_next.inertia   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.enable    <= 1'b0;
            gains_reg.p_gain[0] <= P_GAIN_LOW_RST;
            gains_reg.p_gain[1] <= P_GAIN_MID_RST;
            gains_reg.p_gain[2] <= P_GAIN_HIGH_RST;
            gains_reg.d_gain[0] <= D_GAIN_LOW_RST;
            gains_reg.d_gain[1] <= D_GAIN_MID_RST;
            gains_reg.d_gain[2] <= D_GAIN_HIGH_RST;
            gains_reg.inertia   <= INERTIA_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

endmodule

`default_nettype wire

### sv/gspd_seq.sv
// Microcode sequencer: step counter, control store and wait-on-output jump.
// Depends on gspd_pkg for the control word and control bundle types.
`default_nettype none

module gspd_seq
    import gspd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_stall,
    output ctrl_t ctrl
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_t            word;
    logic              jump;

    function automatic ucode_t uw(
        input acc_op_t           op,
        input a_sel_t            a,
        input b_sel_t            b,
        input logic              hi,
        input logic              pk,
        input logic              sc,
        input cond_t             c,
        input logic [STEP_W-1:0] tgt,
        input logic              lst
    );
        ucode_t w;
        w.acc_op   = op;
        w.a_sel    = a;
        w.b_sel    = b;
        w.hi       = hi;
        w.peak_upd = pk;
        w.sect_upd = sc;
        w.cond     = c;
        w.target   = tgt;
        w.last     = lst;
        return w;
    endfunction

    // velocity term, then PD sum, then inertia product, then round and saturate
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] s);
        ucode_t w;
        case (s)
            4'd0:  w = uw(ACC_NOP,   A_VEL,  B_VEL_COEF, 1'b0, 1'b1, 1'b0, COND_NONE, s, 1'b0);
            4'd1:  w = uw(ACC_LOAD,  A_VEL,  B_VEL_COEF, 1'b1, 1'b0, 1'b1, COND_NONE, s, 1'b0);
            4'd2:  w = uw(ACC_ADD,   A_PERR, B_KP,       1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd3:  w = uw(ACC_VTERM, A_PERR, B_KP,       1'b1, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd4:  w = uw(ACC_ADD,   A_VERR, B_KD,       1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd5:  w = uw(ACC_ADD,   A_VERR, B_KD,       1'b1, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd6:  w = uw(ACC_ADD,   A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd7:  w = uw(ACC_S1,    A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd8:  w = uw(ACC_NOP,   A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd9:  w = uw(ACC_LOAD,  A_S1,   B_INERTIA,  1'b1, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd10: w = uw(ACC_ADD,   A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd11: w = uw(ACC_ROUND, A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b0);
            4'd12: w = uw(ACC_FINAL, A_S1,   B_INERTIA,  1'b0, 1'b0, 1'b0, COND_OUT_STALL, s,
                          1'b1);
            default: w = uw(ACC_NOP, A_VEL,  B_VEL_COEF, 1'b0, 1'b0, 1'b0, COND_NONE, s, 1'b1);
        endcase
        return w;
    endfunction

    always_comb
    begin
        word      = ucode_rom(step_reg);
        jump      = (word.cond == COND_OUT_STALL) && out_stall;
        in_ready  = (state_reg == ST_IDLE);
        ctrl.load = in_valid && (state_reg == ST_IDLE);
        ctrl.exec = (state_reg == ST_RUN) && !jump;
        ctrl.uc   = word;

        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (jump)
                    step_next = word.target;
                else if (word.last)
                    state_next = ST_IDLE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_RUN && step_reg == '0)
        else $error("accepted beat did not start the program at step zero");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> step_reg <= LAST_STEP)
        else $error("step counter ran past the last control word");

endmodule

`default_nettype wire

### sv/gspd_dp.sv
// Datapath: operand capture, peak and sector logic, shared multiplier with
// accumulator, rounding, saturation and the output register.
// Depends on gspd_pkg; driven by the control bundle from gspd_seq.
`default_nettype none

module gspd_dp
    import gspd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_t                        ctrl,
    input  gains_t                       gains,
    input  logic signed [DATA_WIDTH-1:0] meas_position,
    input  logic signed [DATA_WIDTH-1:0] meas_velocity,
    input  logic signed [DATA_WIDTH-1:0] meas_accel,
    input  logic signed [DATA_WIDTH-1:0] target_position,
    input  logic signed [DATA_WIDTH-1:0] target_velocity,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] force_cmd,
    output sector_t                      sector,
    output logic [DATA_WIDTH-2:0]        peak_position
);

    localparam int DW    = DATA_WIDTH;
    localparam int PK_W  = DW - 1;
    localparam int TH_W  = DW + 2;
    localparam int OP_W  = DW + 12;
    localparam int LO_W  = OP_W / 2;
    localparam int HI_W  = OP_W - LO_W;
    localparam int CH_W  = HI_W + 1;
    localparam int BM_W  = GAIN_W + 1;
    localparam int PR_W  = CH_W + BM_W;
    localparam int ACC_W = DW + 36;

    localparam longint unsigned FLOOR_RAW  = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint unsigned PEAK_FLOOR = FLOOR_RAW + ((FLOOR_RAW == 0) ? 64'd1 : 64'd0);
    localparam longint unsigned VEL_COEF   = ((64'd1981 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint unsigned FORCE_BIAS = ((64'd1111 << FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam longint          OUT_MAX_L  = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint          OUT_MIN_L  = -(longint'(1) <<< (DW - 1));

    localparam logic [PK_W-1:0]         PEAK_MAX   = '1;
    localparam logic [PK_W-1:0]         FLOOR_V    = PK_W'(PEAK_FLOOR);
    localparam logic [GAIN_W-1:0]       VEL_COEF_V = GAIN_W'(VEL_COEF);
    localparam logic signed [ACC_W-1:0] BIAS_V     = ACC_W'(FORCE_BIAS);
    localparam logic signed [ACC_W-1:0] OUT_MAX    = ACC_W'(OUT_MAX_L);
    localparam logic signed [ACC_W-1:0] OUT_MIN    = ACC_W'(OUT_MIN_L);

    logic signed [DW-1:0]    pos_reg;
    logic signed [DW-1:0]    vel_reg;
    logic signed [DW-1:0]    accel_reg;
    logic signed [DW-1:0]    tpos_reg;
    logic signed [DW-1:0]    tvel_reg;
    logic [PK_W-1:0]         peak_reg;
    logic [PK_W-1:0]         peak_next;
    sector_t                 sector_reg;
    sector_t                 sector_next;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] vterm_reg;
    logic signed [ACC_W-1:0] vterm_next;
    logic signed [OP_W-1:0]  s1_reg;
    logic signed [OP_W-1:0]  s1_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [DW-1:0]    force_reg;
    logic signed [DW-1:0]    force_next;
    sector_t                 sect_out_reg;
    sector_t                 sect_out_next;
    logic [PK_W-1:0]         peak_out_reg;
    logic [PK_W-1:0]         peak_out_next;

    logic [DW-1:0]           neg_pos;
    logic [PK_W-1:0]         abs_pos;
    logic [PK_W-1:0]         peak_hi;
    logic [PK_W-1:0]         peak_cand;
    logic signed [TH_W-1:0]  three_pos;
    logic signed [TH_W-1:0]  peak_s;
    logic signed [DW:0]      perr;
    logic signed [DW:0]      verr;
    logic signed [OP_W-1:0]  a_op;
    logic [HI_W-1:0]         a_hi;
    logic signed [CH_W-1:0]  chunk;
    logic [GAIN_W-1:0]       b_op;
    logic [GAIN_W-1:0]       kp_sel;
    logic [GAIN_W-1:0]       kd_sel;
    logic signed [BM_W-1:0]  bm;
    logic signed [PR_W-1:0]  prod;
    logic signed [ACC_W-1:0] prod_w;
    logic signed [ACC_W-1:0] r16_sum;
    logic signed [ACC_W-1:0] rnd16;
    logic signed [ACC_W-1:0] rf_sum;
    logic signed [ACC_W-1:0] rndf;
    logic signed [ACC_W-1:0] accel_sh;
    logic signed [DW-1:0]    sat_val;

    assign out_valid     = out_valid_reg;
    assign out_stall     = out_valid_reg && !out_ready;
    assign force_cmd     = force_reg;
    assign sector        = sect_out_reg;
    assign peak_position = peak_out_reg;

    // peak of |position| with saturation of the most negative code and a floor
    always_comb
    begin
        neg_pos = -pos_reg;
        if (pos_reg[DW-1])
            abs_pos = neg_pos[DW-1] ? PEAK_MAX : neg_pos[PK_W-1:0];
        else
            abs_pos = pos_reg[PK_W-1:0];
        peak_hi   = (abs_pos > peak_reg) ? abs_pos : peak_reg;
        peak_cand = (peak_hi < FLOOR_V) ? FLOOR_V : peak_hi;
        peak_next = (ctrl.exec && ctrl.uc.peak_upd) ? peak_cand : peak_reg;
    end

    always_comb
    begin
        three_pos = TH_W'(pos_reg) + (TH_W'(pos_reg) <<< 1);
        peak_s    = signed'({3'b000, peak_reg});
        sector_next = sector_reg;
        if (ctrl.exec && ctrl.uc.sect_upd)
        begin
            if (three_pos <= -peak_s)
                sector_next = SECTOR_LOW;
            else if (three_pos >= peak_s)
                sector_next = SECTOR_HIGH;
            else
                sector_next = SECTOR_MID;
        end
    end

    // shared multiplier: one half of the operand against one gain per step
    always_comb
    begin
        perr = (DW+1)'(tpos_reg) - (DW+1)'(pos_reg);
        verr = (DW+1)'(tvel_reg) - (DW+1)'(vel_reg);

        case (ctrl.uc.a_sel)
            A_VEL:   a_op = OP_W'(vel_reg);
            A_PERR:  a_op = OP_W'(perr);
            A_VERR:  a_op = OP_W'(verr);
            A_S1:    a_op = s1_reg;
            default: a_op = s1_reg;
        endcase

        case (sector_reg)
            SECTOR_LOW:
            begin
                kp_sel = gains.p_gain[0];
                kd_sel = gains.d_gain[0];
            end
            SECTOR_MID:
            begin
                kp_sel = gains.p_gain[1];
                kd_sel = gains.d_gain[1];
            end
            SECTOR_HIGH:
            begin
                kp_sel = gains.p_gain[2];
                kd_sel = gains.d_gain[2];
            end
            default:
            begin
                kp_sel = gains.p_gain[0];
                kd_sel = gains.d_gain[0];
            end
        endcase

        case (ctrl.uc.b_sel)
            B_VEL_COEF: b_op = VEL_COEF_V;
            B_KP:       b_op = kp_sel;
            B_KD:       b_op = kd_sel;
            B_INERTIA:  b_op = gains.inertia;
            default:    b_op = gains.inertia;
        endcase

        a_hi = a_op[OP_W-1:LO_W];
        if (ctrl.uc.hi)
            chunk = signed'({a_hi[HI_W-1], a_hi});
        else
            chunk = signed'({{(CH_W-LO_W){1'b0}}, a_op[LO_W-1:0]});
        bm     = signed'({1'b0, b_op});
        prod   = chunk * bm;
        prod_w = ACC_W'(prod);
        prod_next = ctrl.uc.hi ? (prod_w <<< LO_W) : prod_w;
    end

    // round to nearest, ties away from zero: (v + half - sign) >>> n
    always_comb
    begin
        r16_sum  = acc_reg + (ACC_W'(1) <<< (GAIN_FRAC - 1)) - ACC_W'(acc_reg[ACC_W-1]);
        rnd16    = r16_sum >>> GAIN_FRAC;
        rf_sum   = acc_reg + (ACC_W'(1) <<< (FRAC_BITS - 1)) - ACC_W'(acc_reg[ACC_W-1]);
        rndf     = rf_sum >>> FRAC_BITS;
        accel_sh = ACC_W'(accel_reg) <<< GAIN_FRAC;

        if (acc_reg > OUT_MAX)
            sat_val = OUT_MAX[DW-1:0];
        else if (acc_reg < OUT_MIN)
            sat_val = OUT_MIN[DW-1:0];
        else
            sat_val = acc_reg[DW-1:0];
    end

    always_comb
    begin
        acc_next       = acc_reg;
        vterm_next     = vterm_reg;
        s1_next        = s1_reg;
        force_next     = force_reg;
        sect_out_next  = sect_out_reg;
        peak_out_next  = peak_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (ctrl.exec)
        begin
            case (ctrl.uc.acc_op)
                ACC_NOP: ;
                ACC_LOAD:  acc_next = prod_reg;
                ACC_ADD:   acc_next = acc_reg + prod_reg;
                ACC_VTERM:
                begin
                    vterm_next = rndf + BIAS_V;
                    acc_next   = accel_sh + prod_reg;
                end
                ACC_S1:    s1_next  = OP_W'(rnd16);
                ACC_ROUND: acc_next = rnd16 + vterm_reg;
                ACC_FINAL:
                begin
                    force_next     = gains.enable ? sat_val : '0;
                    sect_out_next  = sector_reg;
                    peak_out_next  = peak_reg;
                    out_valid_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pos_reg   <= meas_position;
            vel_reg   <= meas_velocity;
            accel_reg <= meas_accel;
            tpos_reg  <= target_position;
            tvel_reg  <= target_velocity;
        end
        sector_reg   <= sector_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        vterm_reg    <= vterm_next;
        s1_reg       <= s1_next;
        force_reg    <= force_next;
        sect_out_reg <= sect_out_next;
        peak_out_reg <= peak_out_next;
    end

    a_peak_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg != '0 |=> peak_reg >= $past(peak_reg))
        else $error("position peak decreased");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && ctrl.uc.acc_op == ACC_FINAL && !gains.enable |=> force_reg == '0)
        else $error("force not zero while disabled");

endmodule

`default_nettype wire

### sv/gain_scheduled_pd_force_control.sv
// Each accepted input beat runs the 13-step control program, which puts all
// products through one shared multiplier and accumulator; no new beat is
// accepted until the program has finished with the last one.
// A stalled result holds the final step until the output register is free.
// Reset (rst_n low, asynchronous): sequencer idle, no result pending, position
// peak zero, configuration registers at their defaults with enable cleared.
`default_nettype none

module gain_scheduled_pd_force_control
    import gspd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W      = ((5 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * DATA_WIDTH + 1 + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // meas_position, meas_velocity, meas_accel, target_position, target_velocity
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // force_cmd, sector, peak_position
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [GAIN_W-1:0] cfg_data
);

    localparam int DW = DATA_WIDTH;

    ctrl_t                ctrl;
    gains_t               gains;
    logic                 out_stall;
    logic signed [DW-1:0] force_cmd;
    sector_t              sector;
    logic [DW-2:0]        peak_position;

    gspd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    gspd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    gspd_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .gains           (gains),
        .meas_position   (s_axis_tdata[DW-1:0]),
        .meas_velocity   (s_axis_tdata[2*DW-1:DW]),
        .meas_accel      (s_axis_tdata[3*DW-1:2*DW]),
        .target_position (s_axis_tdata[4*DW-1:3*DW]),
        .target_velocity (s_axis_tdata[5*DW-1:4*DW]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_stall       (out_stall),
        .force_cmd       (force_cmd),
        .sector          (sector),
        .peak_position   (peak_position)
    );

    assign m_axis_tdata = {{(OUT_W - 2 * DW - 1){1'b0}}, peak_position, sector, force_cmd};

endmodule

`default_nettype wire
